// ----- rtl/core/tps_pkg.sv -----
// Package for the tachometer period-to-speed converter: widths, reset values,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tps_pkg;

  // Timer and field widths
  localparam int TIMER_BITS = 24;
  localparam int CPS_W      = 27;
  localparam int PPR_W      = 5;
  localparam int MILLI_W    = 10;
  localparam int SPEED_W    = 32;

  // Dividend is 1000 * clocks_per_second, divisor is pulses * period
  localparam int NUM_W = CPS_W + MILLI_W;
  localparam int DEN_W = PPR_W + TIMER_BITS;

  // One quotient bit per divide step
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Stream widths (whole bytes)
  localparam int S_TDATA_W = ((TIMER_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((TIMER_BITS + SPEED_W + 7) / 8) * 8;

  // Configuration register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CPS_W;

  localparam logic [MILLI_W-1:0] MILLI_SCALE = MILLI_W'(1000);
  localparam logic [CPS_W-1:0]   CPS_RESET   = CPS_W'(80000000);
  localparam logic [PPR_W-1:0]   PPR_RESET   = PPR_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPS = 1'b0,
    REG_PPR = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tps_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take the input item, form the period
    logic mul;       // form dividend and divisor, clear remainder
    logic step;      // one restoring divide step
    logic out_load;  // move the result into the output register
  } tps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } tps_status_t;

endpackage

// ----- rtl/core/tps_ctrl.sv -----
// Controller for the tachometer converter: sequences accept, multiply,
// bit-serial divide and output load. Depends on tps_pkg.
`timescale 1ns / 1ps

module tps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tps_pkg::tps_status_t status_i,
  output tps_pkg::tps_cmd_t   cmd_o
);
  import tps_pkg::*;

  tps_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_step;

  assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (last_step) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_DIV:  cmd_o.step = 1'b1;
      ST_DONE: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/tps_dpath.sv -----
// Datapath for the tachometer converter: configuration registers, previous
// capture, multipliers, restoring divider and output register. Depends on tps_pkg.
`timescale 1ns / 1ps

module tps_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [tps_pkg::TIMER_BITS-1:0] capture_i,
  input  tps_pkg::tps_cmd_t             cmd_i,
  output tps_pkg::tps_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tps_pkg::TIMER_BITS-1:0] out_period_o,
  output logic [tps_pkg::SPEED_W-1:0]   out_speed_o,
  output logic                          out_sat_o
);
  import tps_pkg::*;

  logic [CPS_W-1:0]      cps_q;
  logic [PPR_W-1:0]      ppr_q;
  logic [TIMER_BITS-1:0] prev_q;
  logic [TIMER_BITS-1:0] period_q;
  logic [DEN_W-1:0]      denom_q;
  logic [NUM_W-1:0]      nq_q, nq_d;
  logic [DEN_W-1:0]      rem_q, rem_d;
  logic                  out_valid_q;
  logic [TIMER_BITS-1:0] out_period_q;
  logic [SPEED_W-1:0]    out_speed_q;
  logic                  out_sat_q;

  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  fits;
  logic                  sat;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= CPS_RESET;
      ppr_q <= PPR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CPS: cps_q <= cfg_wdata_i;
        REG_PPR: ppr_q <= cfg_wdata_i[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Previous capture starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.load) begin
      prev_q <= capture_i;
    end
  end

  // Restoring divide step: shift in one dividend bit, subtract when it fits
  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign diff  = trial - {1'b0, denom_q};
  assign fits  = (trial >= {1'b0, denom_q});
  assign rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign nq_d  = {nq_q[NUM_W-2:0], fits};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      period_q <= prev_q - capture_i;
    end
    if (cmd_i.mul) begin
      nq_q    <= NUM_W'(cps_q) * NUM_W'(MILLI_SCALE);
      denom_q <= DEN_W'(ppr_q) * DEN_W'(period_q);
      rem_q   <= '0;
    end else if (cmd_i.step) begin
      nq_q  <= nq_d;
      rem_q <= rem_d;
    end
  end

  // Zero divisor or a quotient beyond the speed width saturates
  assign sat = (denom_q == '0) || (|nq_q[NUM_W-1:SPEED_W]);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_period_q <= period_q;
      out_speed_q  <= sat ? '1 : nq_q[SPEED_W-1:0];
      out_sat_q    <= sat;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_period_o      = out_period_q;
  assign out_speed_o       = out_speed_q;
  assign out_sat_o         = out_sat_q;

endmodule

// ----- rtl/core/tach_period_to_speed.sv -----
// Top level of the tachometer period-to-speed converter.
// Instantiates tps_ctrl and tps_dpath; depends on tps_pkg.
`timescale 1ns / 1ps

// Each input item is one capture of a 24-bit down-counting timer taken at a
// tachometer edge. The block keeps the previous capture (zero after reset),
// forms the period as previous minus new modulo 2^24, and returns one result
// item per input: the period and the speed in thousandths of rotations per
// second, 1000 * clocks_per_second / (pulses_per_rotation * period),
// truncated. A zero divisor or a quotient wider than 32 bits gives
// 0xFFFFFFFF with the saturated flag set. Each item passes in turn through
// acceptance, the two multiplies, the one-bit-per-cycle restoring divider
// and the load of the output register; the next item is accepted only after
// that load. The input is taken again while a finished result waits in that
// register; a held result stalls only the following item at its load step.
// Write configuration while idle.
module tach_period_to_speed (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: index 0 clocks_per_second, index 1 pulses_per_rotation
  input  logic                           cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tps_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [23:0] capture_time
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tps_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [23:0] period_cycles,
                                                       // [55:24] speed_thousandths
  output logic                           m_axis_tuser   // [0] saturated
);
  import tps_pkg::*;

  tps_cmd_t              cmd;
  tps_status_t           status;
  logic [TIMER_BITS-1:0] out_period;
  logic [SPEED_W-1:0]    out_speed;

  // Sequencing: accept, multiply, divide, load output
  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic, state and output register
  tps_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .capture_i    (s_axis_tdata[TIMER_BITS-1:0]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_period_o (out_period),
    .out_speed_o  (out_speed),
    .out_sat_o    (m_axis_tuser)
  );

  // Pack period in the low bits, speed above it
  assign m_axis_tdata = M_TDATA_W'({out_speed, out_period});

endmodule
